// ===== rtl/ivm_pkg.sv =====
package ivm_pkg;

  // Defaults for the top-level parameters
  localparam int IVM_STORE_WORDS   = 65536;
  localparam int IVM_FRACTION_BITS = 20;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 17;
  localparam int WEIGHT_BITS = 16;
  localparam int SPEED_FRAC_W = 20;

  // Gain saturates at 0.25 in Q16
  localparam logic [14:0] GAIN_LIMIT = 15'd16384;

  // Saturation limits of a 16-bit sample
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_MIX   = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_WHOLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FRAC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 3'd6;

  // Voice configuration handed from the register file to the core
  typedef struct packed {
    logic [15:0] sample_count;
    logic        stereo_mode;
    logic [3:0]  speed_whole;
    logic [19:0] speed_frac;
    logic [14:0] left_gain;
    logic [14:0] right_gain;
    logic        loop_enable;
  } ivm_cfg_t;

  // Frame sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REM,
    S_READ,
    S_WAIT,
    S_BLEND,
    S_GAIN,
    S_DONE
  } ivm_state_t;

endpackage

// ===== rtl/ivm_chan_if.sv =====
// Request channel
interface ivm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        word_addr;
  logic signed [15:0] word_value;
  logic signed [15:0] mix_in_left;
  logic signed [15:0] mix_in_right;
  logic [15:0]        start_position;
  logic [19:0]        start_fraction;

  modport source (
    output valid, req_type, word_addr, word_value, mix_in_left, mix_in_right,
           start_position, start_fraction,
    input  ready
  );
  modport sink (
    input  valid, req_type, word_addr, word_value, mix_in_left, mix_in_right,
           start_position, start_fraction,
    output ready
  );
endinterface

// Result channel
interface ivm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_out_left;
  logic signed [15:0] mix_out_right;
  logic               voice_finished;

  modport source (
    output valid, mix_out_left, mix_out_right, voice_finished,
    input  ready
  );
  modport sink (
    input  valid, mix_out_left, mix_out_right, voice_finished,
    output ready
  );
endinterface

// ===== rtl/ivm_store.sv =====
module ivm_store import ivm_pkg::*; #(
  parameter int  DEPTH = IVM_STORE_WORDS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ivm_rem.sv =====
module ivm_rem import ivm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [15:0]      remainder
);

  localparam int CNT_W = $clog2(POS_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] quo_r;
  logic [POS_W-1:0] rem_r;
  logic [POS_W-1:0] trial;

  // Restoring step: shift in one dividend bit, subtract when it fits
  assign trial = {rem_r[POS_W-2:0], quo_r[POS_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(POS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[POS_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_r <= trial - {1'b0, divisor};
      end else begin
        rem_r <= trial;
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[15:0];

endmodule

// ===== rtl/ivm_lane.sv =====
module ivm_lane import ivm_pkg::*; (
  input  logic                       clk,
  input  logic                       blend_en,
  input  logic                       gain_en,
  input  logic signed [SAMPLE_W-1:0] cur,
  input  logic signed [SAMPLE_W-1:0] nxt,
  input  logic [WEIGHT_BITS-1:0]     weight,
  input  logic [14:0]                gain,
  input  logic signed [SAMPLE_W-1:0] base,
  output logic signed [SAMPLE_W-1:0] mix_out
);

  logic signed [16:0] diff;
  logic signed [16:0] w_s;
  logic signed [33:0] p1_r;
  logic signed [17:0] v18;
  logic signed [15:0] v16;
  logic [14:0]        gain_c;
  logic signed [15:0] g_s;
  logic signed [31:0] p2_r;
  logic signed [15:0] contrib;
  logic signed [16:0] sum17;

  // cur*(1-w) + nxt*w rewritten as cur + (nxt-cur)*w
  assign diff = {nxt[15], nxt} - {cur[15], cur};
  assign w_s  = {1'b0, weight};

  always_ff @(posedge clk) begin
    if (blend_en) begin
      p1_r <= diff * w_s;
    end
  end

  // Floor of the blend: cur plus arithmetic shift of the product
  assign v18 = {{2{cur[15]}}, cur} + p1_r[33:16];
  assign v16 = v18[15:0];

  // Gain clamped to 0.25
  assign gain_c = (gain > GAIN_LIMIT) ? GAIN_LIMIT : gain;
  assign g_s    = {1'b0, gain_c};

  always_ff @(posedge clk) begin
    if (gain_en) begin
      p2_r <= v16 * g_s;
    end
  end

  // Add onto the incoming value, saturate on overflow
  assign contrib = p2_r[31:16];
  assign sum17   = {base[15], base} + {contrib[15], contrib};

  always_comb begin
    if (sum17[16] != sum17[15]) begin
      mix_out = sum17[16] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      mix_out = sum17[15:0];
    end
  end

endmodule

// ===== rtl/ivm_core.sv =====
module ivm_core import ivm_pkg::*; #(
  parameter int STORE_WORDS   = IVM_STORE_WORDS,
  parameter int FRACTION_BITS = IVM_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ivm_cfg_t  cfg,
  ivm_in_if.sink    in_chan,
  ivm_out_if.source out_chan
);

  localparam int AW  = $clog2(STORE_WORDS);
  localparam int CWA = $clog2(STORE_WORDS + 1);
  localparam int CW  = (CWA > POS_W + 1) ? CWA : POS_W + 1;
  localparam int SW  = ((FRACTION_BITS > SPEED_FRAC_W) ? FRACTION_BITS : SPEED_FRAC_W) + 1;
  localparam logic [CW-1:0] STORE_LIMIT = CW'(STORE_WORDS);

  ivm_state_t state_r, state_nxt;

  logic                     accept;
  logic                     out_free;
  logic                     past_end;
  logic                     pass_thru;
  logic                     rem_start;
  logic                     rem_done;
  logic [15:0]              rem_val;

  logic [POS_W-1:0]         pos_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic                     finished_r;
  logic signed [15:0]       base_l_r;
  logic signed [15:0]       base_r_r;

  // Read sequencer
  logic [1:0]               rd_k_r;
  logic [1:0]               rd_last;
  logic                     rd_vld_r;
  logic [1:0]               rd_slot_r;
  logic                     rd_ok_r;
  logic [POS_W-1:0]         nxt_pos;
  logic [POS_W-1:0]         rd_pos;
  logic [CW-1:0]            rd_addr;
  logic [SAMPLE_W-1:0]      rdata;
  logic signed [15:0]       cur_l_r, nxt_l_r, cur_r_r, nxt_r_r;

  // Store write
  logic [CW-1:0]            waddr;
  logic                     mem_we;

  // Position advance
  logic [SW-1:0]            fsum;
  logic [SW-1:0]            start_frac_ext;
  logic [POS_W-1:0]         pos_adv;

  // Results
  logic signed [15:0]       lane_l, lane_r;
  logic                     out_load;
  logic                     out_valid_r;
  logic signed [15:0]       out_l_r, out_r_r;
  logic                     out_fin_r;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  assign past_end  = pos_r >= {1'b0, cfg.sample_count};
  assign pass_thru = (cfg.sample_count == 16'd0) || (past_end && !cfg.loop_enable);

  // Next state
  always_comb begin
    state_nxt = state_r;
    rem_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_chan.req_type == REQ_MIX) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (pass_thru) begin
          state_nxt = S_DONE;
        end else if (past_end) begin
          rem_start = 1'b1;
          state_nxt = S_REM;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_REM: begin
        if (rem_done) state_nxt = S_READ;
      end
      S_READ: begin
        if (rd_k_r == rd_last) state_nxt = S_WAIT;
      end
      S_WAIT:  state_nxt = S_BLEND;
      S_BLEND: state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Wrap modulo the sample count when looping
  ivm_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (pos_r),
    .divisor   (cfg.sample_count),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Read addresses: mono cur, nxt; stereo cur left, nxt left, cur right, nxt right
  assign nxt_pos = (pos_r + 1'b1 == {1'b0, cfg.sample_count}) ? '0 : pos_r + 1'b1;
  assign rd_last = cfg.stereo_mode ? 2'd3 : 2'd1;
  assign rd_pos  = rd_k_r[0] ? nxt_pos : pos_r;
  assign rd_addr = cfg.stereo_mode ? CW'({rd_pos, ~rd_k_r[1]}) : CW'(rd_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_k_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_READ);
      if (state_r == S_READ) begin
        rd_k_r <= rd_k_r + 1'b1;
      end else begin
        rd_k_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_k_r;
    rd_ok_r   <= rd_addr < STORE_LIMIT;
  end

  // Capture read beats; words outside the store read as zero
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_slot_r)
        2'd0: cur_l_r <= rd_ok_r ? rdata : '0;
        2'd1: nxt_l_r <= rd_ok_r ? rdata : '0;
        2'd2: cur_r_r <= rd_ok_r ? rdata : '0;
        2'd3: nxt_r_r <= rd_ok_r ? rdata : '0;
        default: ;
      endcase
    end
  end

  // Writes are taken only when idle, so no read can be in flight on the same word
  assign waddr  = CW'(in_chan.word_addr);
  assign mem_we = accept && (in_chan.req_type == REQ_WRITE) && (waddr < STORE_LIMIT);

  ivm_store #(.DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr[AW-1:0]),
    .wdata (in_chan.word_value),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  // Interpolation and gain lanes
  ivm_lane u_lane_l (
    .clk      (clk),
    .blend_en (state_r == S_BLEND),
    .gain_en  (state_r == S_GAIN),
    .cur      (cur_l_r),
    .nxt      (nxt_l_r),
    .weight   (frac_r[FRACTION_BITS-1 -: WEIGHT_BITS]),
    .gain     (cfg.left_gain),
    .base     (base_l_r),
    .mix_out  (lane_l)
  );

  ivm_lane u_lane_r (
    .clk      (clk),
    .blend_en (state_r == S_BLEND),
    .gain_en  (state_r == S_GAIN),
    .cur      (cfg.stereo_mode ? cur_r_r : cur_l_r),
    .nxt      (cfg.stereo_mode ? nxt_r_r : nxt_l_r),
    .weight   (frac_r[FRACTION_BITS-1 -: WEIGHT_BITS]),
    .gain     (cfg.right_gain),
    .base     (base_r_r),
    .mix_out  (lane_r)
  );

  // Position step: fraction carry goes into the whole position
  assign fsum    = SW'(frac_r) + SW'(cfg.speed_frac);
  assign pos_adv = pos_r + POS_W'(cfg.speed_whole) + POS_W'(fsum >> FRACTION_BITS);
  assign start_frac_ext = SW'(in_chan.start_fraction);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      frac_r <= '0;
    end else if (accept && in_chan.req_type == REQ_SET) begin
      pos_r  <= POS_W'(in_chan.start_position);
      frac_r <= start_frac_ext[FRACTION_BITS-1:0];
    end else if (state_r == S_REM && rem_done) begin
      pos_r <= POS_W'(rem_val);
    end else if (out_load && !finished_r) begin
      pos_r  <= pos_adv;
      frac_r <= fsum[FRACTION_BITS-1:0];
    end
  end

  // Per-frame payload
  always_ff @(posedge clk) begin
    if (accept && in_chan.req_type == REQ_MIX) begin
      base_l_r <= in_chan.mix_in_left;
      base_r_r <= in_chan.mix_in_right;
    end
    if (state_r == S_CHECK) begin
      finished_r <= pass_thru;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r   <= finished_r ? base_l_r : lane_l;
      out_r_r   <= finished_r ? base_r_r : lane_r;
      out_fin_r <= finished_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.mix_out_left   = out_l_r;
  assign out_chan.mix_out_right  = out_r_r;
  assign out_chan.voice_finished = out_fin_r;

  // Reads only ever run from a position inside the sample range
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (pos_r < {1'b0, cfg.sample_count}))
    else $error("read issued from a position past the end");

  // A finished frame leaves the play position alone
  a_pass_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && finished_r) |=> ($stable(pos_r) && $stable(frac_r)))
    else $error("position moved on a finished frame");

  // A waiting result is never overwritten
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> (state_r == S_DONE))
    else $error("frame result left S_DONE while output stalled");

  // A new result beat only follows the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside S_DONE");

endmodule

// ===== rtl/interpolating_voice_mixer.sv =====
// One voice of a resampling sample mixer.
// in_chan (valid/ready) carries requests: write a sample word, mix one frame,
// or set the play position. out_chan (valid/ready) returns one beat per mix
// request: the saturated left/right sums and a finished flag; writes and
// position sets return nothing. cfg_we/cfg_index/cfg_wdata write the voice
// registers only while the voice is idle: a rule the block does not enforce.
// A mix request runs through the check, read, wait, blend and gain states to
// the done state, which loads the result; the next request is taken in the
// cycle after the load. The pace is set by the single read port of the
// sample memory (one word per cycle, 2 or 4 words per frame) plus the blend
// and gain multiply stages. When the position has run past the end with
// looping on, a bit-serial remainder unit runs before the reads. A finished
// frame (past end, no loop, or a zero sample count) skips to the done state.
// Reset clears the play position and fraction and loads the register
// defaults; the sample memory is not cleared and must be written before use.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and works until its own result needs that
// register.
module interpolating_voice_mixer import ivm_pkg::*; #(
  parameter int STORE_WORDS   = IVM_STORE_WORDS,
  parameter int FRACTION_BITS = IVM_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ivm_in_if.sink                in_chan,
  ivm_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ivm_cfg_t cfg_r;

  // Voice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count   <= 16'd16;
      cfg_r.stereo_mode    <= 1'b0;
      cfg_r.speed_whole    <= 4'd1;
      cfg_r.speed_frac     <= '0;
      cfg_r.left_gain      <= '0;
      cfg_r.right_gain     <= '0;
      cfg_r.loop_enable    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT:   cfg_r.sample_count   <= cfg_wdata[15:0];
        CFG_STEREO_MODE:    cfg_r.stereo_mode    <= cfg_wdata[0];
        CFG_SPEED_WHOLE:    cfg_r.speed_whole    <= cfg_wdata[3:0];
        CFG_SPEED_FRAC:     cfg_r.speed_frac     <= cfg_wdata[19:0];
        CFG_LEFT_GAIN:      cfg_r.left_gain      <= cfg_wdata[14:0];
        CFG_RIGHT_GAIN:     cfg_r.right_gain     <= cfg_wdata[14:0];
        CFG_LOOP_ENABLE:    cfg_r.loop_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ivm_core #(
    .STORE_WORDS   (STORE_WORDS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
